// ----- hw/rtl/tid_pkg.sv -----
// ---------------------------------------------------------------------------
// tid_pkg
// Shared types and constants for the Telnet IAC deframer.
// ---------------------------------------------------------------------------
`default_nettype none

package tid_pkg;

  localparam logic [7:0] TN_IAC  = 8'd255;
  localparam logic [7:0] TN_SE   = 8'd240;
  localparam logic [7:0] TN_GA   = 8'd249;
  localparam logic [7:0] TN_SB   = 8'd250;
  localparam logic [7:0] TN_WILL = 8'd251;
  localparam logic [7:0] TN_WONT = 8'd252;
  localparam logic [7:0] TN_DO   = 8'd253;
  localparam logic [7:0] TN_DONT = 8'd254;

  localparam logic [7:0] OPT_ECHO = 8'd1;
  localparam logic [7:0] OPT_GMCP = 8'd201;

  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_OFF_GA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GA_TO_LF     = 2'd1;

  localparam logic [1:0] SB_COUNT_MAX = 2'd3;

  typedef enum logic [2:0] {
    EV_DATA    = 3'd0,
    EV_REPLY   = 3'd1,
    EV_PROMPT  = 3'd2,
    EV_LF      = 3'd3,
    EV_ECHOON  = 3'd4,
    EV_ECHOOFF = 3'd5,
    EV_SBEND   = 3'd6
  } event_kind_e;

  typedef struct packed {
    logic force_off_ga;
    logic ga_to_lf;
  } cfg_t;

  typedef struct packed {
    logic        has;
    event_kind_e kind;
    logic [7:0]  text;
    logic [7:0]  verb;
    logic [7:0]  opt;
    logic        gmcp;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tid_parser.sv -----
// ---------------------------------------------------------------------------
// tid_parser
// Telnet command state and per-byte decode; produces at most one result.
// ---------------------------------------------------------------------------
`default_nettype none

module tid_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire logic [7:0]       byte_i,
  input  wire tid_pkg::cfg_t    cfg_i,
  output tid_pkg::result_t      res_o
);
  import tid_pkg::*;

  logic       after_iac_q, after_iac_d;
  logic       await_opt_q, await_opt_d;
  logic       in_sb_q, in_sb_d;
  logic [7:0] verb_q, verb_d;
  logic [7:0] sb_opt_q, sb_opt_d;
  logic [1:0] sb_cnt_q, sb_cnt_d;
  logic       gmcp_q, gmcp_d;
  result_t    res;

  always_comb begin
    after_iac_d = after_iac_q;
    await_opt_d = await_opt_q;
    in_sb_d     = in_sb_q;
    verb_d      = verb_q;
    sb_opt_d    = sb_opt_q;
    sb_cnt_d    = sb_cnt_q;
    gmcp_d      = gmcp_q;
    res         = '0;
    res.kind    = EV_DATA;
    if (fire_i) begin
      if (await_opt_q) begin
        await_opt_d = 1'b0;
        if (verb_q == TN_WILL) begin
          priority if (byte_i == OPT_ECHO) begin
            res.has  = 1'b1;
            res.kind = EV_ECHOOFF;
          end else if (byte_i == OPT_GMCP) begin
            if (!gmcp_q) begin
              gmcp_d   = 1'b1;
              res.has  = 1'b1;
              res.kind = EV_REPLY;
              res.verb = TN_DO;
              res.opt  = OPT_GMCP;
            end
          end else begin
            res.has  = 1'b1;
            res.kind = EV_REPLY;
            res.verb = TN_DONT;
            res.opt  = byte_i;
          end
        end else if (verb_q == TN_WONT) begin
          if (byte_i == OPT_ECHO) begin
            res.has  = 1'b1;
            res.kind = EV_ECHOON;
          end
        end else if (verb_q == TN_DO) begin
          res.has  = 1'b1;
          res.kind = EV_REPLY;
          if (byte_i == OPT_GMCP) begin
            gmcp_d   = 1'b1;
            res.verb = TN_WILL;
            res.opt  = OPT_GMCP;
          end else begin
            res.verb = TN_WONT;
            res.opt  = byte_i;
          end
        end
      end else if (in_sb_q) begin
        if (after_iac_q && byte_i == TN_SE) begin
          if (sb_opt_q == OPT_GMCP && sb_cnt_q == SB_COUNT_MAX) begin
            res.has  = 1'b1;
            res.kind = EV_SBEND;
            res.opt  = OPT_GMCP;
          end
          in_sb_d     = 1'b0;
          after_iac_d = 1'b0;
        end else begin
          if (sb_cnt_q == 2'd0) begin
            sb_opt_d = byte_i;
          end
          if (sb_cnt_q != SB_COUNT_MAX) begin
            sb_cnt_d = sb_cnt_q + 2'd1;
          end
          if (after_iac_q) begin
            after_iac_d = 1'b0;
          end else if (byte_i == TN_IAC) begin
            after_iac_d = 1'b1;
          end
        end
      end else if (after_iac_q) begin
        after_iac_d = 1'b0;
        if (byte_i == TN_IAC) begin
          res.has  = 1'b1;
          res.kind = EV_DATA;
          res.text = TN_IAC;
        end else if (byte_i >= TN_WILL && byte_i <= TN_DONT) begin
          await_opt_d = 1'b1;
          verb_d      = byte_i;
        end else if (byte_i == TN_SB) begin
          in_sb_d  = 1'b1;
          sb_cnt_d = 2'd0;
          sb_opt_d = 8'd0;
        end else if (byte_i == TN_GA) begin
          if (!cfg_i.force_off_ga) begin
            res.has  = 1'b1;
            res.kind = EV_PROMPT;
          end else if (cfg_i.ga_to_lf) begin
            res.has  = 1'b1;
            res.kind = EV_LF;
          end
        end
      end else if (byte_i == TN_IAC) begin
        after_iac_d = 1'b1;
      end else if (byte_i != CH_CR) begin
        res.has  = 1'b1;
        res.kind = EV_DATA;
        res.text = byte_i;
      end
    end
    res.gmcp = gmcp_d;
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_iac_q <= 1'b0;
      await_opt_q <= 1'b0;
      in_sb_q     <= 1'b0;
      verb_q      <= 8'd0;
      sb_opt_q    <= 8'd0;
      sb_cnt_q    <= 2'd0;
      gmcp_q      <= 1'b0;
    end else begin
      after_iac_q <= after_iac_d;
      await_opt_q <= await_opt_d;
      in_sb_q     <= in_sb_d;
      verb_q      <= verb_d;
      sb_opt_q    <= sb_opt_d;
      sb_cnt_q    <= sb_cnt_d;
      gmcp_q      <= gmcp_d;
    end
  end

  a_opt_not_sb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(await_opt_q && in_sb_q))
    else $error("option wait inside subnegotiation");

  a_opt_no_iac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(await_opt_q && after_iac_q))
    else $error("option wait with IAC pending");

  a_gmcp_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gmcp_q |=> gmcp_q)
    else $error("GMCP flag cleared");

  a_sbend_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.has && res.kind == EV_SBEND) |-> (in_sb_q && sb_cnt_q == SB_COUNT_MAX))
    else $error("subneg end without payload");

endmodule

`default_nettype wire

// ----- hw/rtl/tid_out_stage.sv -----
// ---------------------------------------------------------------------------
// tid_out_stage
// Result register toward the consumer; frees itself as the item is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module tid_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire tid_pkg::result_t res_i,
  output logic                  free_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output tid_pkg::result_t      res_o
);
  import tid_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result overwritten before taken");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ready_i) |=> (valid_q && $stable(res_q)))
    else $error("stalled result changed");

  a_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> valid_q)
    else $error("loaded result not shown");

endmodule

`default_nettype wire

// ----- hw/rtl/telnet_iac_deframer.sv -----
// ---------------------------------------------------------------------------
// telnet_iac_deframer
// Splits a received byte stream into text and Telnet IAC command events.
// ---------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  rx       in         in_valid_i / in_ready_o   rx_byte_i
//  event    out        out_valid_o / out_ready_i event_kind_o, text_byte_o,
//                                                reply_verb_o, option_code_o,
//                                                gmcp_active_o
//  cfg      in         cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
//  One byte per cycle sustained while the event side takes each event; each
//  byte waits in the input register, is decoded and, if it yields an event,
//  sits in the result register from the next cycle. Reset clears all command
//  state and settings; a stalled result register holds the decode stage,
//  which in turn holds the input.
// ---------------------------------------------------------------------------
`default_nettype none

module telnet_iac_deframer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [7:0]                     rx_byte_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [2:0]                          event_kind_o,
  output logic [7:0]                          text_byte_o,
  output logic [7:0]                          reply_verb_o,
  output logic [7:0]                          option_code_o,
  output logic                                gmcp_active_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [tid_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic                           cfg_wdata_i
);
  import tid_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       fire;
  logic       out_free;
  result_t    res;
  result_t    res_out;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FORCE_OFF_GA: cfg_d.force_off_ga = cfg_wdata_i;
        CFG_GA_TO_LF:     cfg_d.ga_to_lf     = cfg_wdata_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  assign fire       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || fire;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= '0;
      in_valid_q <= 1'b0;
    end else begin
      cfg_q      <= cfg_d;
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  tid_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_byte_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  tid_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire && res.has),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res_out)
  );

  assign event_kind_o  = 3'(res_out.kind);
  assign text_byte_o   = res_out.text;
  assign reply_verb_o  = res_out.verb;
  assign option_code_o = res_out.opt;
  assign gmcp_active_o = res_out.gmcp;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !fire) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("pending item lost");

  a_fire_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> (in_valid_q && out_free))
    else $error("decode without item");

  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |-> !in_ready_o)
    else $error("accept while stalled");

endmodule

`default_nettype wire

// ----- bench/telnet_iac_deframer_tb.sv -----
// ---------------------------------------------------------------------------
// telnet_iac_deframer_tb
// Self-checking bench for the Telnet IAC deframer. A queue-fed driver offers
// received bytes, a clocked monitor predicts the event each accepted byte
// produces and checks every event against the oldest prediction. The run
// steps through several go-ahead settings, random idling on both sides, a
// long receiver hold-off and a stretch at full rate.
// ---------------------------------------------------------------------------
module telnet_iac_deframer_tb;
  import tid_pkg::*;

  localparam int DRAIN_CYCLES = 6;
  localparam int IDLE_PCT     = 15;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  typedef struct packed {
    event_kind_e kind;
    logic [7:0]  text;
    logic [7:0]  verb;
    logic [7:0]  opt;
    logic        gmcp;
  } tn_event_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [7:0]           rx_byte_i = 8'd0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [2:0]           event_kind_o;
  logic [7:0]           text_byte_o;
  logic [7:0]           reply_verb_o;
  logic [7:0]           option_code_o;
  logic                 gmcp_active_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic                 cfg_wdata_i = 1'b0;

  telnet_iac_deframer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_kind_o  (event_kind_o),
    .text_byte_o   (text_byte_o),
    .reply_verb_o  (reply_verb_o),
    .option_code_o (option_code_o),
    .gmcp_active_o (gmcp_active_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // predictor state and settings
  bit         force_off_ga = 1'b0;
  bit         ga_to_lf = 1'b0;
  bit         st_after_iac = 1'b0;
  bit         st_want_opt = 1'b0;
  bit         st_in_sb = 1'b0;
  logic [7:0] st_verb = 8'd0;
  logic [7:0] st_sb_opt = 8'd0;
  logic [1:0] st_sb_cnt = 2'd0;
  bit         st_gmcp = 1'b0;

  logic [7:0] rx_pending[$];
  tn_event_t  events_due[$];
  bit         rx_fire = 1'b0;
  bit         hold_rx = 1'b0;
  bit         calm = 1'b0;
  int         rx_count = 0;
  int         ev_count = 0;
  int         errors = 0;
  int         kind_seen[0:6];

  function automatic void deframe_byte(input logic [7:0] b);
    tn_event_t ev;
    bit        hit;
    hit = 1'b0;
    ev.kind = EV_DATA;
    ev.text = 8'd0;
    ev.verb = 8'd0;
    ev.opt  = 8'd0;
    if (st_want_opt) begin
      st_want_opt = 1'b0;
      case (st_verb)
        TN_WILL: begin
          if (b == OPT_ECHO) begin
            hit = 1'b1; ev.kind = EV_ECHOOFF;
          end else if (b == OPT_GMCP) begin
            if (!st_gmcp) begin
              st_gmcp = 1'b1;
              hit = 1'b1; ev.kind = EV_REPLY; ev.verb = TN_DO; ev.opt = OPT_GMCP;
            end
          end else begin
            hit = 1'b1; ev.kind = EV_REPLY; ev.verb = TN_DONT; ev.opt = b;
          end
        end
        TN_WONT: begin
          if (b == OPT_ECHO) begin
            hit = 1'b1; ev.kind = EV_ECHOON;
          end
        end
        TN_DO: begin
          hit = 1'b1;
          ev.kind = EV_REPLY;
          if (b == OPT_GMCP) begin
            st_gmcp = 1'b1;
            ev.verb = TN_WILL; ev.opt = OPT_GMCP;
          end else begin
            ev.verb = TN_WONT; ev.opt = b;
          end
        end
        default: ;
      endcase
    end else if (st_in_sb) begin
      if (st_after_iac && b == TN_SE) begin
        if (st_sb_opt == OPT_GMCP && st_sb_cnt == SB_COUNT_MAX) begin
          hit = 1'b1; ev.kind = EV_SBEND; ev.opt = OPT_GMCP;
        end
        st_in_sb = 1'b0;
        st_after_iac = 1'b0;
      end else begin
        if (st_sb_cnt == 2'd0) st_sb_opt = b;
        if (st_sb_cnt != SB_COUNT_MAX) st_sb_cnt = st_sb_cnt + 2'd1;
        if (st_after_iac) st_after_iac = 1'b0;
        else if (b == TN_IAC) st_after_iac = 1'b1;
      end
    end else if (st_after_iac) begin
      st_after_iac = 1'b0;
      if (b == TN_IAC) begin
        hit = 1'b1; ev.text = TN_IAC;
      end else if (b >= TN_WILL && b <= TN_DONT) begin
        st_want_opt = 1'b1;
        st_verb = b;
      end else if (b == TN_SB) begin
        st_in_sb = 1'b1;
        st_sb_cnt = 2'd0;
        st_sb_opt = 8'd0;
      end else if (b == TN_GA) begin
        if (!force_off_ga) begin
          hit = 1'b1; ev.kind = EV_PROMPT;
        end else if (ga_to_lf) begin
          hit = 1'b1; ev.kind = EV_LF;
        end
      end
    end else if (b == TN_IAC) begin
      st_after_iac = 1'b1;
    end else if (b != CH_CR) begin
      hit = 1'b1; ev.text = b;
    end
    if (hit) begin
      ev.gmcp = st_gmcp;
      events_due.push_back(ev);
    end
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("MISMATCH: %s", msg);
  endtask

  // check the oldest event first, then predict from the byte taken this edge
  always @(posedge clk_i) begin : event_check
    tn_event_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (events_due.size() == 0) begin
        note_error($sformatf("unexpected event kind %0d text %02h verb %0d opt %0d gmcp %0d",
                             event_kind_o, text_byte_o, reply_verb_o, option_code_o,
                             gmcp_active_o));
      end else begin
        want = events_due.pop_front();
        ev_count++;
        kind_seen[want.kind]++;
        if (event_kind_o !== want.kind || text_byte_o !== want.text ||
            reply_verb_o !== want.verb || option_code_o !== want.opt ||
            gmcp_active_o !== want.gmcp)
          note_error($sformatf(
            "event %0d: expected kind %0d text %02h verb %0d opt %0d gmcp %0d, got %0d %02h %0d %0d %0d",
            ev_count, want.kind, want.text, want.verb, want.opt, want.gmcp,
            event_kind_o, text_byte_o, reply_verb_o, option_code_o, gmcp_active_o));
      end
    end
    rx_fire = rst_ni && in_valid_i && in_ready_o;
    if (rx_fire) begin
      deframe_byte(rx_byte_i);
      rx_count++;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || rx_fire)) begin
      if (rx_pending.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid_i <= 1'b1;
        rx_byte_i  <= rx_pending.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= !hold_rx && (calm || $urandom_range(0, 99) >= IDLE_PCT);
  end

  // stall the event side while bytes keep coming, so the block backs up
  initial begin
    wait (rx_count >= 250);
    @(posedge clk_i);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx = 1'b0;
  end

  initial begin
    #4000000;
    $display("telnet_iac_deframer_tb: done, errors");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_FORCE_OFF_GA) force_off_ga = val;
    else if (idx == CFG_GA_TO_LF) ga_to_lf = val;
  endtask

  task automatic set_mode(input logic force_off, input logic to_lf);
    write_reg(CFG_FORCE_OFF_GA, force_off);
    write_reg(CFG_GA_TO_LF, to_lf);
    @(posedge clk_i);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while ((rx_pending.size() != 0 || in_valid_i || events_due.size() != 0) &&
           guard < 50000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_cmd(input logic [7:0] verb, input logic [7:0] opt);
    rx_pending.push_back(TN_IAC);
    rx_pending.push_back(verb);
    rx_pending.push_back(opt);
  endtask

  function automatic logic [7:0] pick_opt();
    case ($urandom_range(0, 3))
      0: return OPT_ECHO;
      1: return OPT_GMCP;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_sequence();
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      rx_pending.push_back(8'($urandom_range(0, 254)));
    end else if (r < 40) begin
      rx_pending.push_back(CH_CR);
    end else if (r < 45) begin
      rx_pending.push_back(TN_IAC);
      rx_pending.push_back(TN_IAC);
    end else if (r < 55) begin
      rx_pending.push_back(TN_IAC);
      rx_pending.push_back(TN_GA);
    end else if (r < 75) begin
      send_cmd(8'($urandom_range(TN_WILL, TN_DONT)), pick_opt());
    end else if (r < 80) begin
      rx_pending.push_back(TN_IAC);
      rx_pending.push_back(8'($urandom_range(TN_SE, TN_GA - 1)));
    end else if (r < 93) begin
      rx_pending.push_back(TN_IAC);
      rx_pending.push_back(TN_SB);
      rx_pending.push_back(($urandom_range(0, 3) != 0) ? OPT_GMCP :
                           8'($urandom_range(0, 255)));
      len = $urandom_range(0, 4);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 5) == 0) begin
          rx_pending.push_back(TN_IAC);
          rx_pending.push_back(TN_IAC);
        end else begin
          rx_pending.push_back(8'($urandom_range(0, 254)));
        end
      end
      // leave a few subnegotiations open so later bytes get swallowed
      if ($urandom_range(0, 7) != 0) begin
        rx_pending.push_back(TN_IAC);
        rx_pending.push_back(TN_SE);
      end
    end else begin
      rx_pending.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic fill_random(input int n);
    int start;
    start = rx_pending.size();
    while (rx_pending.size() - start < n) queue_sequence();
  endtask

  initial begin
    foreach (kind_seen[k]) kind_seen[k] = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: go-ahead is a prompt mark
    rx_pending.push_back(8'h00);
    rx_pending.push_back(CH_CR);
    rx_pending.push_back(CH_LF);
    rx_pending.push_back(TN_IAC);
    rx_pending.push_back(TN_IAC);
    rx_pending.push_back(TN_IAC);
    rx_pending.push_back(TN_GA);
    send_cmd(TN_WILL, OPT_ECHO);
    send_cmd(TN_WONT, OPT_ECHO);
    send_cmd(TN_WILL, TN_IAC);
    send_cmd(TN_WILL, OPT_GMCP);
    send_cmd(TN_DO, OPT_GMCP);
    rx_pending.push_back(TN_IAC);
    rx_pending.push_back(TN_SB);
    rx_pending.push_back(OPT_GMCP);
    rx_pending.push_back(TN_IAC);
    rx_pending.push_back(TN_IAC);
    rx_pending.push_back(TN_IAC);
    rx_pending.push_back(TN_SE);
    fill_random(80);
    drain();

    set_mode(1'b1, 1'b1);
    fill_random(110);
    drain();

    // spare indexes must leave both settings alone
    set_mode(1'b1, 1'b0);
    write_reg(CFG_IDX_SPARE_A, 1'b0);
    write_reg(CFG_IDX_SPARE_B, 1'b1);
    @(posedge clk_i);
    fill_random(110);
    drain();

    set_mode(1'b0, 1'b1);
    calm = 1'b1;
    fill_random(110);
    drain();
    calm = 1'b0;

    set_mode(1'b0, 1'b0);
    fill_random(100);
    drain();

    if (events_due.size() != 0) begin
      errors += events_due.size();
      $display("MISMATCH: %0d expected events never arrived", events_due.size());
    end
    $display("run: %0d bytes over five go-ahead phases, %0d events checked, %0d-cycle stall",
             rx_count, ev_count, HOLD_CYCLES);
    $display("events: data %0d reply %0d prompt %0d lf %0d echo on %0d off %0d sb end %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             kind_seen[5], kind_seen[6]);
    if (errors == 0) $display("telnet_iac_deframer_tb: done, clean");
    else $display("telnet_iac_deframer_tb: done, errors");
    $finish;
  end

endmodule
